@@ hdl/ocvg_pkg.sv @@
// Package for the one-pole coefficient vector generator.
// Holds field widths, parameter defaults and the cell-to-cell link type.
// No dependencies.
package ocvg_pkg;

  // Field widths
  localparam int CUTOFF_W = 15;
  localparam int INDEX_W  = 4;
  localparam int COEF_W   = 14;
  localparam int GAIN_W   = 15;

  // Running power is Q30, always below 2^30
  localparam int POWER_W  = 30;
  localparam int PROD_W   = POWER_W + COEF_W;
  localparam int Q14_SH   = 14;
  localparam int Q30_SH   = 16;

  // Q14 unity
  localparam logic [GAIN_W-1:0] Q14_ONE = 15'd16384;

  // Parameter defaults
  localparam int VECTOR_WORDS_DEF  = 16;
  localparam int LEADING_ZEROS_DEF = 8;

  // Word handed from one cell to the next
  typedef struct packed {
    logic               valid;
    logic [COEF_W-1:0]  pole;
    logic [POWER_W-1:0] power;
  } link_t;

endpackage

@@ hdl/onepole_coef_vector_gen.sv @@
// One-pole lowpass coefficient vector generator, top level.
// The first word leaves via the first cell's register and the output register, the last
// via the last cell's. One word per cycle, VECTOR_WORDS (16 by default) per vector;
// a cutoff walks the cell chain, and the single result port sets the pace.
// Reset: synchronous active-low rst_n clears all occupancy flags; no word pending.
// The receiver cannot stall; busy drops while the previous vector's last word is in flight.
module onepole_coef_vector_gen #(
  parameter int VECTOR_WORDS  = ocvg_pkg::VECTOR_WORDS_DEF,
  parameter int LEADING_ZEROS = ocvg_pkg::LEADING_ZEROS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ocvg_pkg::CUTOFF_W-1:0] in_cutoff,
  output logic                          out_strobe,
  output logic [ocvg_pkg::INDEX_W-1:0]  out_coef_index,
  output logic [ocvg_pkg::COEF_W-1:0]   out_coef_value,
  output logic [ocvg_pkg::GAIN_W-1:0]   out_filter_gain,
  output logic                          out_last
);
  import ocvg_pkg::*;

  link_t             head;
  link_t             links [VECTOR_WORDS];
  logic [COEF_W-1:0] words [VECTOR_WORDS];
  logic              busy_c;

  // Busy while any cell but the last holds a word
  always_comb begin
    busy_c = 1'b0;
    for (int k = 0; k < VECTOR_WORDS - 1; k++) begin
      busy_c = busy_c | links[k].valid;
    end
  end
  assign busy = busy_c;

  // Chain input: pole is cutoff shifted right by one
  assign head.valid = start & ~busy_c;
  assign head.pole  = in_cutoff[CUTOFF_W-1:1];
  assign head.power = '0;

  // Cell chain
  for (genvar g = 0; g < VECTOR_WORDS; g++) begin : g_cell
    ocvg_cell #(
      .CELL_POS      (g),
      .LEADING_ZEROS (LEADING_ZEROS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .link_i ((g == 0) ? head : links[(g == 0) ? 0 : g - 1]),
      .link_o (links[g]),
      .word_o (words[g])
    );
  end

  ocvg_out #(
    .VECTOR_WORDS (VECTOR_WORDS)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .links_i         (links),
    .words_i         (words),
    .out_strobe      (out_strobe),
    .out_coef_index  (out_coef_index),
    .out_coef_value  (out_coef_value),
    .out_filter_gain (out_filter_gain),
    .out_last        (out_last)
  );

endmodule

@@ hdl/ocvg_cell.sv @@
// One cell of the coefficient chain: computes the word for its vector position.
// Depends on ocvg_pkg.
module ocvg_cell #(
  parameter int CELL_POS      = 0,
  parameter int LEADING_ZEROS = ocvg_pkg::LEADING_ZEROS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ocvg_pkg::link_t               link_i,
  output ocvg_pkg::link_t               link_o,
  output logic [ocvg_pkg::COEF_W-1:0]   word_o
);
  import ocvg_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [POWER_W-1:0] power_nxt;
  logic [COEF_W-1:0]  word_nxt;
  logic               valid_r;
  logic [COEF_W-1:0]  pole_r;
  logic [POWER_W-1:0] power_r;
  logic [COEF_W-1:0]  word_r;

  // Next power of the pole, truncated back to Q30
  assign prod = PROD_W'(link_i.power) * PROD_W'(link_i.pole);

  always_comb begin
    if (CELL_POS < LEADING_ZEROS) begin
      power_nxt = '0;
      word_nxt  = '0;
    end else if (CELL_POS == LEADING_ZEROS) begin
      power_nxt = {link_i.pole, {Q30_SH{1'b0}}};
      word_nxt  = link_i.pole;
    end else begin
      power_nxt = prod[Q14_SH +: POWER_W];
      word_nxt  = power_nxt[Q30_SH +: COEF_W];
    end
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= link_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pole_r  <= link_i.pole;
    power_r <= power_nxt;
    word_r  <= word_nxt;
  end

  assign link_o.valid = valid_r;
  assign link_o.pole  = pole_r;
  assign link_o.power = power_r;
  assign word_o       = word_r;

endmodule

@@ hdl/ocvg_out.sv @@
// Output stage: picks the occupied cell and registers the result word.
// Depends on ocvg_pkg.
module ocvg_out #(
  parameter int VECTOR_WORDS = ocvg_pkg::VECTOR_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ocvg_pkg::link_t               links_i [VECTOR_WORDS],
  input  logic [ocvg_pkg::COEF_W-1:0]   words_i [VECTOR_WORDS],
  output logic                          out_strobe,
  output logic [ocvg_pkg::INDEX_W-1:0]  out_coef_index,
  output logic [ocvg_pkg::COEF_W-1:0]   out_coef_value,
  output logic [ocvg_pkg::GAIN_W-1:0]   out_filter_gain,
  output logic                          out_last
);
  import ocvg_pkg::*;

  logic               sel_valid;
  logic [INDEX_W-1:0] sel_index;
  logic [COEF_W-1:0]  sel_word;
  logic [COEF_W-1:0]  sel_pole;
  logic               sel_last;
  logic               strobe_r;
  logic [INDEX_W-1:0] index_r;
  logic [COEF_W-1:0]  value_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               last_r;

  // At most one cell is occupied; OR together its fields
  always_comb begin
    sel_valid = 1'b0;
    sel_index = '0;
    sel_word  = '0;
    sel_pole  = '0;
    sel_last  = 1'b0;
    for (int k = 0; k < VECTOR_WORDS; k++) begin
      if (links_i[k].valid) begin
        sel_valid = 1'b1;
        sel_index = sel_index | INDEX_W'(k);
        sel_word  = sel_word | words_i[k];
        sel_pole  = sel_pole | links_i[k].pole;
        sel_last  = sel_last | (k == VECTOR_WORDS - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    index_r <= sel_index;
    value_r <= sel_word;
    gain_r  <= Q14_ONE - GAIN_W'(sel_pole);
    last_r  <= sel_last;
  end

  assign out_strobe      = strobe_r;
  assign out_coef_index  = index_r;
  assign out_coef_value  = value_r;
  assign out_filter_gain = gain_r;
  assign out_last        = last_r;

endmodule

@@ hdl/ocvg_checker.sv @@
// Port-level checker for onepole_coef_vector_gen, attached by bind.
// Depends on ocvg_pkg.
module ocvg_checker #(
  parameter int VECTOR_WORDS = ocvg_pkg::VECTOR_WORDS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [ocvg_pkg::INDEX_W-1:0]  out_coef_index,
  input logic [ocvg_pkg::GAIN_W-1:0]   out_filter_gain,
  input logic                          out_last
);
  import ocvg_pkg::*;

  localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(VECTOR_WORDS - 1);

  // A taken cutoff makes the block busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after start");

  // First word, at index zero, shows once start has passed a cell register and the output register
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 (out_strobe && out_coef_index == '0))
    else $error("first word missing");

  // Words of a vector are contiguous
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap inside vector");

  // Gain holds across a vector
  a_gain_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> $stable(out_filter_gain))
    else $error("gain changed inside vector");

  // Last marker sits on the final position
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> (out_coef_index == LAST_IDX))
    else $error("last on wrong position");

endmodule

bind onepole_coef_vector_gen ocvg_checker #(
  .VECTOR_WORDS (VECTOR_WORDS)
) u_ocvg_checker (.*);
